// File: hw/rtl/cdpg_pkg.sv
// Shared types, codes and widths for the command driven pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package cdpg_pkg;

	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int LEVEL_W  = 18;
	localparam int ELAP_W   = 15;
	localparam int LIMIT_W  = 16;
	localparam int SCALE_W  = 10;

	localparam int TICKS_PER_SECOND_DEF = 100;

	localparam logic [SCALE_W-1:0] AMP_GAIN   = SCALE_W'(562);
	localparam logic [LEVEL_W-1:0] AMP_OFFSET = LEVEL_W'(259);

	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_W      = 8'h57;
	localparam logic [BYTE_W-1:0] CH_L      = 8'h4C;
	localparam logic [BYTE_W-1:0] CH_H      = 8'h48;
	localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
	localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
	localparam logic [BYTE_W-1:0] CH_S      = 8'h53;

	typedef enum logic [OP_W-1:0] {
		OP_BYTE  = 2'd0,
		OP_US    = 2'd1,
		OP_CENTI = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PM_IDLE   = 3'd0,
		PM_LETTER = 3'd1,
		PM_W      = 3'd2,
		PM_L      = 3'd3,
		PM_H      = 3'd4,
		PM_T      = 3'd5
	} parse_t;

	typedef struct packed {
		logic               run;
		logic               timed;
		logic               restart;
		logic               tick_us;
		logic [BYTE_W-1:0]  low_time;
		logic [BYTE_W-1:0]  high_time;
		logic [LEVEL_W-1:0] amplitude;
	} ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/cdpg_ctrl.sv
// Command parser, run control, settings and single-run timer.
`timescale 1ns / 1ps
`default_nettype none
module cdpg_ctrl #(
	parameter int TICKS_PER_SECOND = cdpg_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [cdpg_pkg::OP_W-1:0]   op,
	input  wire logic [cdpg_pkg::BYTE_W-1:0] rx_byte,
	output cdpg_pkg::ctrl_t                  ctrl
);
	import cdpg_pkg::*;

	parse_t               parse_q, parse_d;
	logic                 run_q, run_d, timed_q, timed_d, restart;
	logic [BYTE_W-1:0]    width_q, width_d, low_q, low_d, high_q, high_d, secs_q, secs_d;
	logic [LEVEL_W-1:0]   amp_q, amp_d, scaled;
	logic [ELAP_W-1:0]    elap_q, elap_d, elap_inc;
	logic [LIMIT_W-1:0]   limit;

	assign scaled   = LEVEL_W'(AMP_GAIN) * LEVEL_W'(width_q);
	assign limit    = LIMIT_W'(TICKS_PER_SECOND) * LIMIT_W'(secs_q);
	assign elap_inc = elap_q + ELAP_W'(1);

	always_comb begin
		parse_d = parse_q;
		run_d   = run_q;
		timed_d = timed_q;
		width_d = width_q;
		low_d   = low_q;
		high_d  = high_q;
		secs_d  = secs_q;
		amp_d   = amp_q;
		elap_d  = elap_q;
		restart = 1'b0;
		case (op_t'(op))
			OP_BYTE: begin
				case (parse_q)
					PM_LETTER: begin
						if (rx_byte == CH_W) begin
							parse_d = PM_W;
						end else if (rx_byte == CH_L) begin
							parse_d = PM_L;
						end else if (rx_byte == CH_H) begin
							parse_d = PM_H;
						end else if (rx_byte == CH_T) begin
							parse_d = PM_T;
						end else if (rx_byte == CH_C) begin
							timed_d = 1'b0;
							restart = 1'b1;
							parse_d = PM_IDLE;
						end else if (rx_byte == CH_S) begin
							run_d   = 1'b0;
							parse_d = PM_IDLE;
						end
					end
					PM_W: begin
						width_d = rx_byte;
						parse_d = PM_IDLE;
					end
					PM_L: begin
						low_d   = rx_byte;
						parse_d = PM_IDLE;
					end
					PM_H: begin
						high_d  = rx_byte;
						parse_d = PM_IDLE;
					end
					PM_T: begin
						secs_d  = rx_byte;
						timed_d = 1'b1;
						restart = 1'b1;
						parse_d = PM_IDLE;
					end
					default: begin
						parse_d = (rx_byte == CH_DOLLAR) ? PM_LETTER : PM_IDLE;
					end
				endcase
			end
			OP_CENTI: begin
				if (run_q && timed_q) begin
					if (LIMIT_W'(elap_inc) >= limit) begin
						run_d  = 1'b0;
						elap_d = '0;
					end else begin
						elap_d = elap_inc;
					end
				end
			end
			default: begin
			end
		endcase
		if (restart) begin
			amp_d  = (scaled > AMP_OFFSET) ? (scaled - AMP_OFFSET) : '0;
			run_d  = 1'b1;
			elap_d = '0;
		end
	end

	always_comb begin
		ctrl.run       = run_d;
		ctrl.timed     = timed_d;
		ctrl.restart   = restart;
		ctrl.tick_us   = (op_t'(op) == OP_US) && run_q;
		ctrl.low_time  = low_d;
		ctrl.high_time = high_d;
		ctrl.amplitude = amp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= PM_IDLE;
			run_q   <= 1'b0;
			timed_q <= 1'b0;
			width_q <= '0;
			low_q   <= '0;
			high_q  <= '0;
			secs_q  <= '0;
			amp_q   <= '0;
			elap_q  <= '0;
		end else if (en) begin
			parse_q <= parse_d;
			run_q   <= run_d;
			timed_q <= timed_d;
			width_q <= width_d;
			low_q   <= low_d;
			high_q  <= high_d;
			secs_q  <= secs_d;
			amp_q   <= amp_d;
			elap_q  <= elap_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/cdpg_phase.sv
// High/low phase counter and output level select.
`timescale 1ns / 1ps
`default_nettype none
module cdpg_phase (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire cdpg_pkg::ctrl_t               ctrl,
	output logic [cdpg_pkg::LEVEL_W-1:0]       level
);
	import cdpg_pkg::*;

	logic              low_q, low_d;
	logic [BYTE_W-1:0] cnt_q, cnt_d, cnt_inc, len;

	assign cnt_inc = cnt_q + BYTE_W'(1);
	assign len     = low_q ? ctrl.low_time : ctrl.high_time;

	always_comb begin
		low_d = low_q;
		cnt_d = cnt_q;
		if (ctrl.restart) begin
			low_d = 1'b0;
			cnt_d = '0;
		end else if (ctrl.tick_us) begin
			if (cnt_inc >= len) begin
				cnt_d = '0;
				low_d = low_q ? 1'b0 : (ctrl.low_time != '0);
			end else begin
				cnt_d = cnt_inc;
			end
		end
	end

	assign level = (ctrl.run && !(low_d && ctrl.low_time != '0)) ? ctrl.amplitude : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 1'b0;
			cnt_q <= '0;
		end else if (en) begin
			low_q <= low_d;
			cnt_q <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/command_driven_pulse_generator_top.sv
// Top level: input register, control and phase logic, result register.
//
//  channel | signals                               | direction
//  in      | in_valid, in_ready, op, rx_byte       | into block
//  out     | out_valid, out_ready, drive_level,    | out of block
//          | running, single_run                   |
//
// One result per transaction; each passes through the input register and then the result register.
// One transaction per cycle sustained while out_ready is high; the state update between the input
// register and the result register sets the rate.
// Reset: stopped, parser idle, all settings and counters zero.
// A stalled output holds the input register; in_ready drops only when both are full
// and out_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module command_driven_pulse_generator_top #(
	parameter int TICKS_PER_SECOND = cdpg_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cdpg_pkg::OP_W-1:0]    op,
	input  wire logic [cdpg_pkg::BYTE_W-1:0]  rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [cdpg_pkg::LEVEL_W-1:0]      drive_level,
	output logic                              running,
	output logic                              single_run
);
	import cdpg_pkg::*;

	logic               valid_s1, adv;
	logic [OP_W-1:0]    op_s1;
	logic [BYTE_W-1:0]  byte_s1;
	ctrl_t              ctrl;
	logic [LEVEL_W-1:0] level;
	logic               out_valid_q, running_q, single_q;
	logic [LEVEL_W-1:0] level_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	cdpg_ctrl #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.op     (op_s1),
		.rx_byte(byte_s1),
		.ctrl   (ctrl)
	);

	cdpg_phase u_phase (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.ctrl  (ctrl),
		.level (level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q   <= level;
			running_q <= ctrl.run;
			single_q  <= ctrl.timed;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_level = level_q;
	assign running     = running_q;
	assign single_run  = single_q;

	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !running_q |-> level_q == '0)
		else $error("drive level nonzero while stopped");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed transaction did not reach output");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(op_s1) && $stable(byte_s1))
		else $error("input register lost a stalled transaction");

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> level_q <= LEVEL_W'(143051))
		else $error("drive level out of range");

endmodule
`default_nettype wire
